>>> src/slsce_pkg.sv
// Shared types and constants of the small load/store core execute unit.
// Holds the transaction structs, operation and error codes and the register reset table.
// Depends on nothing; imported by small_load_store_core_execute_unit.
package slsce_pkg;

   localparam int REG_COUNT  = 10;
   localparam int MEM_DEPTH  = 128;
   localparam int DATA_WIDTH = 32;
   localparam int INIT_COUNT = 5;

   localparam int REG_AW     = $clog2(REG_COUNT);
   localparam int DS_AW      = $clog2(MEM_DEPTH);
   localparam int INIT_AW    = $clog2(INIT_COUNT);
   localparam int PC_W       = 8;
   localparam int IMM_W      = 16;
   localparam int DIV_CNT_W  = $clog2(DATA_WIDTH);

   localparam logic [PC_W-1:0] PC_LIMIT = 8'd128;

   // Operation codes.
   localparam logic [3:0] MODE_LOAD   = 4'd0;
   localparam logic [3:0] MODE_STORE  = 4'd1;
   localparam logic [3:0] MODE_ADD    = 4'd2;
   localparam logic [3:0] MODE_SUB    = 4'd3;
   localparam logic [3:0] MODE_ADDIMM = 4'd4;
   localparam logic [3:0] MODE_MULT   = 4'd5;
   localparam logic [3:0] MODE_MOD    = 4'd6;
   localparam logic [3:0] MODE_BEQ    = 4'd7;
   localparam logic [3:0] MODE_JUMP   = 4'd8;

   // Error codes.
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_MOD_ZERO   = 2'd1;
   localparam logic [1:0] ERR_BAD_ADDR   = 2'd2;
   localparam logic [1:0] ERR_BAD_TARGET = 2'd3;

   // Configuration register index.
   localparam logic CSR_PROGRAM_LENGTH = 1'b0;

   localparam logic [DATA_WIDTH-1:0] REG_INIT [INIT_COUNT] = '{
      DATA_WIDTH'(1), DATA_WIDTH'(1), DATA_WIDTH'(1), DATA_WIDTH'(0), DATA_WIDTH'(100)
   };

   typedef struct packed {
      logic [3:0]              mode;
      logic [3:0]              dest_reg;
      logic [3:0]              src_a_reg;
      logic [3:0]              src_b_reg;
      logic signed [IMM_W-1:0] immediate;
   } req_item_type;

   typedef struct packed {
      logic [PC_W-1:0]              next_pc;
      logic                         write_enable;
      logic [3:0]                   write_reg;
      logic signed [DATA_WIDTH-1:0] write_value;
      logic                         branch_taken;
      logic                         halted;
      logic [1:0]                   error_code;
   } rsp_item_type;

   // Reset value of a register; entries past the table reset to zero.
   function automatic logic [DATA_WIDTH-1:0] reg_init_value(input logic [3:0] idx);
      logic [DATA_WIDTH-1:0] val;
      val = '0;
      if (int'(idx) < INIT_COUNT) begin
         val = REG_INIT[idx[INIT_AW-1:0]];
      end
      return val;
   endfunction

endpackage

>>> src/small_load_store_core_execute_unit.sv
// Execute unit of a small load/store core: register file, data store and program counter.
// Register file and data store are synchronous memories read at accept, written at commit.
// Depends on slsce_pkg.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_data (req_item_type)
//   rsp_      out        rsp_valid / rsp_stall  rsp_data (rsp_item_type)
//   csr_      in/out     APB psel/penable       program_length at byte address 0
//
// One instruction is worked on at a time. Most pass through the memory read at accept and
// an execute cycle that commits the result. Modulo with a nonzero divisor then runs the
// 1-bit-per-cycle restoring divider (32 iterations plus a sign fix) before it commits.
// A finished result waits in the output register while the next transaction is accepted;
// a further result waits in the execute stage while rsp_stall holds the output register.
// Reset is synchronous; valid bits make the memories read their reset values at once.
module small_load_store_core_execute_unit
   import slsce_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_item_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_item_type       rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_FIN
   } state_type;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DATA_WIDTH - 1);

   state_type             state_ff;
   req_item_type          item_ff;
   logic [PC_W-1:0]       pc_ff;
   logic [PC_W-1:0]       plen_ff;
   logic                  rsp_valid_ff;
   rsp_item_type          rsp_data_ff;

   // Memories and their valid bits.
   logic [DATA_WIDTH-1:0] rf_mem [REG_COUNT];
   logic [DATA_WIDTH-1:0] ds_mem [MEM_DEPTH];
   logic                  rf_valid_ff [REG_COUNT];
   logic                  ds_valid_ff [MEM_DEPTH];

   // Registered read data and side information.
   logic [DATA_WIDTH-1:0] rf_rdata_a_ff;
   logic [DATA_WIDTH-1:0] rf_rdata_b_ff;
   logic [DATA_WIDTH-1:0] ds_rdata_ff;
   logic                  rf_a_inr_ff;
   logic                  rf_b_inr_ff;
   logic                  rf_a_vld_ff;
   logic                  rf_b_vld_ff;
   logic [DATA_WIDTH-1:0] rf_a_init_ff;
   logic [DATA_WIDTH-1:0] rf_b_init_ff;
   logic                  ds_vld_ff;

   // Divider.
   logic [DATA_WIDTH-1:0] div_rem_ff;
   logic [DATA_WIDTH-1:0] div_num_ff;
   logic [DATA_WIDTH-1:0] div_den_ff;
   logic                  div_neg_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [DATA_WIDTH:0]   div_trial;
   logic [DATA_WIDTH:0]   div_diff;
   logic [DATA_WIDTH-1:0] div_rem_in;

   logic                  accept;
   logic                  csr_write;
   logic [3:0]            rf_raddr_a;
   logic [3:0]            rf_raddr_b;
   logic [DS_AW-1:0]      ds_raddr;

   logic [PC_W-1:0]       len;
   logic [DATA_WIDTH-1:0] a_val;
   logic [DATA_WIDTH-1:0] b_val;
   logic [DATA_WIDTH-1:0] load_val;
   logic [DATA_WIDTH-1:0] imm_ext;
   logic [IMM_W-2:0]      imm_mag;
   logic                  imm_neg;
   logic                  dest_inr;
   logic                  we;
   logic                  we_eff;
   logic                  ds_we_raw;
   logic                  taken;
   logic                  div_start;
   logic [1:0]            err;
   logic [PC_W-1:0]       npc;
   logic [DATA_WIDTH-1:0] wval;
   rsp_item_type          res;
   logic                  out_free;
   logic                  commit;
   logic                  rf_we;
   logic                  ds_we;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_PROGRAM_LENGTH) ? {24'd0, plen_ff} : 32'd0;

   // Store reads the register named by dest_reg; branch compares it against src_a_reg.
   assign rf_raddr_a = (req_data.mode == MODE_STORE || req_data.mode == MODE_BEQ)
                       ? req_data.dest_reg : req_data.src_a_reg;
   assign rf_raddr_b = (req_data.mode == MODE_BEQ) ? req_data.src_a_reg : req_data.src_b_reg;
   assign ds_raddr   = req_data.immediate[DS_AW-1:0];

   assign len      = (plen_ff > PC_LIMIT) ? PC_LIMIT : plen_ff;
   assign a_val    = !rf_a_inr_ff ? '0 : (rf_a_vld_ff ? rf_rdata_a_ff : rf_a_init_ff);
   assign b_val    = !rf_b_inr_ff ? '0 : (rf_b_vld_ff ? rf_rdata_b_ff : rf_b_init_ff);
   assign load_val = ds_vld_ff ? ds_rdata_ff : '0;
   assign imm_ext  = DATA_WIDTH'(item_ff.immediate);
   assign imm_neg  = item_ff.immediate[IMM_W-1];
   assign imm_mag  = item_ff.immediate[IMM_W-2:0];
   assign dest_inr = int'(item_ff.dest_reg) < REG_COUNT;

   // One restoring step of the unsigned magnitude division.
   assign div_trial  = {div_rem_ff, div_num_ff[DATA_WIDTH-1]};
   assign div_diff   = div_trial - {1'b0, div_den_ff};
   assign div_rem_in = div_diff[DATA_WIDTH] ? div_trial[DATA_WIDTH-1:0]
                                            : div_diff[DATA_WIDTH-1:0];

   always_comb begin
      we        = 1'b0;
      ds_we_raw = 1'b0;
      taken     = 1'b0;
      div_start = 1'b0;
      err       = ERR_NONE;
      wval      = '0;
      npc       = pc_ff + 8'd1;
      unique case (state_ff)
         ST_EXEC: begin
            if (pc_ff >= len) begin
               npc = pc_ff;
            end else begin
               unique case (item_ff.mode)
                  MODE_LOAD, MODE_STORE: begin
                     if (imm_neg || int'(imm_mag) >= MEM_DEPTH) begin
                        err = ERR_BAD_ADDR;
                     end else if (item_ff.mode == MODE_LOAD) begin
                        we   = 1'b1;
                        wval = load_val;
                     end else if (int'(imm_mag) >= int'(len)) begin
                        // Stores into the program area are dropped without error.
                        ds_we_raw = 1'b1;
                        wval      = a_val;
                     end
                  end
                  MODE_ADD: begin
                     we   = 1'b1;
                     wval = a_val + b_val;
                  end
                  MODE_SUB: begin
                     we   = 1'b1;
                     wval = a_val - b_val;
                  end
                  MODE_ADDIMM: begin
                     we   = 1'b1;
                     wval = a_val + imm_ext;
                  end
                  MODE_MULT: begin
                     we   = 1'b1;
                     wval = a_val * b_val;
                  end
                  MODE_MOD: begin
                     we = 1'b1;
                     if (b_val == '0) begin
                        err = ERR_MOD_ZERO;
                     end else begin
                        div_start = 1'b1;
                     end
                  end
                  MODE_BEQ, MODE_JUMP: begin
                     if (item_ff.mode == MODE_JUMP || a_val == b_val) begin
                        if (imm_neg || int'(imm_mag) >= int'(PC_LIMIT)) begin
                           err = ERR_BAD_TARGET;
                        end else begin
                           taken = 1'b1;
                           npc   = imm_mag[PC_W-1:0];
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIN: begin
            we   = 1'b1;
            wval = div_neg_ff ? (~div_rem_ff + 1'b1) : div_rem_ff;
         end
         default: begin
         end
      endcase
      if (err != ERR_NONE) begin
         npc = pc_ff;
      end
      we_eff = we && dest_inr;

      res.next_pc      = npc;
      res.write_enable = we_eff;
      res.write_reg    = we_eff ? item_ff.dest_reg : 4'd0;
      res.write_value  = wval;
      res.branch_taken = taken;
      res.halted       = (err != ERR_NONE) || (npc >= len);
      res.error_code   = err;
   end

   assign commit = out_free && ((state_ff == ST_EXEC && !div_start) || state_ff == ST_FIN);
   assign rf_we  = commit && we_eff;
   assign ds_we  = commit && ds_we_raw;

   // Register file: two read ports at accept, one write port at commit.
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[item_ff.dest_reg[REG_AW-1:0]] <= wval;
      end
      if (accept) begin
         rf_rdata_a_ff <= rf_mem[rf_raddr_a[REG_AW-1:0]];
         rf_rdata_b_ff <= rf_mem[rf_raddr_b[REG_AW-1:0]];
      end
   end

   // Data store: one read port at accept, one write port at commit.
   always_ff @(posedge clock) begin
      if (ds_we) begin
         ds_mem[item_ff.immediate[DS_AW-1:0]] <= wval;
      end
      if (accept) begin
         ds_rdata_ff <= ds_mem[ds_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         plen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) begin
            rf_valid_ff[i] <= 1'b0;
         end
         for (int i = 0; i < MEM_DEPTH; i++) begin
            ds_valid_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_write && csr_paddr[2] == CSR_PROGRAM_LENGTH) begin
            plen_ff <= csr_pwdata[PC_W-1:0];
         end
         if (rf_we) begin
            rf_valid_ff[item_ff.dest_reg[REG_AW-1:0]] <= 1'b1;
         end
         if (ds_we) begin
            ds_valid_ff[item_ff.immediate[DS_AW-1:0]] <= 1'b1;
         end

         if (commit) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= res.next_pc;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (div_start) begin
                  state_ff <= ST_DIV;
               end else if (commit) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV: begin
               if (div_cnt_ff == DIV_LAST) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (commit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end

      // Payload registers.
      if (accept) begin
         item_ff      <= req_data;
         rf_a_inr_ff  <= int'(rf_raddr_a) < REG_COUNT;
         rf_b_inr_ff  <= int'(rf_raddr_b) < REG_COUNT;
         rf_a_vld_ff  <= rf_valid_ff[rf_raddr_a[REG_AW-1:0]];
         rf_b_vld_ff  <= rf_valid_ff[rf_raddr_b[REG_AW-1:0]];
         rf_a_init_ff <= reg_init_value(rf_raddr_a);
         rf_b_init_ff <= reg_init_value(rf_raddr_b);
         ds_vld_ff    <= ds_valid_ff[ds_raddr];
      end
      if (commit) begin
         rsp_data_ff <= res;
      end
      if (state_ff == ST_EXEC && div_start) begin
         div_rem_ff <= '0;
         div_num_ff <= a_val[DATA_WIDTH-1] ? (~a_val + 1'b1) : a_val;
         div_den_ff <= b_val[DATA_WIDTH-1] ? (~b_val + 1'b1) : b_val;
         div_neg_ff <= a_val[DATA_WIDTH-1];
         div_cnt_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         div_rem_ff <= div_rem_in;
         div_num_ff <= {div_num_ff[DATA_WIDTH-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted transaction did not enter the execute cycle");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && div_cnt_ff == DIV_LAST |=> state_ff == ST_FIN)
      else $error("divider did not finish after its last iteration");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ERR_NONE |-> rsp_data.halted && !rsp_data.branch_taken)
      else $error("error result does not report a halt");

   a_pc_bound: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_LIMIT)
      else $error("program counter beyond its limit");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> !(commit && $past(rsp_valid && rsp_stall) && rsp_stall) ||
         !rsp_valid_ff)
      else $error("result committed over a stalled output");
`endif

endmodule
